// File: hw/rtl/segment_rule_automaton_step_defines.svh
// ---------------------------------------------------------------------------
// segment_rule_automaton_step assertion macros
// shared assertion forms, sampled on clock and disabled during reset
// ---------------------------------------------------------------------------
`ifndef SEGMENT_RULE_AUTOMATON_STEP_DEFINES_SVH
`define SEGMENT_RULE_AUTOMATON_STEP_DEFINES_SVH

// same-cycle implication
`define SRA_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sra assertion failed");

// next-cycle implication
`define SRA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sra assertion failed");

`endif

// File: hw/rtl/sra_pkg.sv
// ---------------------------------------------------------------------------
// sra_pkg
// shared types, microcode encodings and program for the automaton step block
// ---------------------------------------------------------------------------
package sra_pkg;

   localparam int IMAGE_BYTES_DEFAULT = 65536;
   localparam int PC_W = 4;

   // datapath operations
   localparam logic [3:0] OP_NOP      = 4'd0;
   localparam logic [3:0] OP_ACCEPT   = 4'd1;
   localparam logic [3:0] OP_LD_CNT   = 4'd2;
   localparam logic [3:0] OP_LD_SHIFT = 4'd3;
   localparam logic [3:0] OP_LD_HI    = 4'd4;
   localparam logic [3:0] OP_LD_LO    = 4'd5;
   localparam logic [3:0] OP_LD_FLAGS = 4'd6;
   localparam logic [3:0] OP_LD_SINK  = 4'd7;
   localparam logic [3:0] OP_UPDATE   = 4'd8;
   localparam logic [3:0] OP_ADVANCE  = 4'd9;
   localparam logic [3:0] OP_FINISH   = 4'd10;

   // read address selects
   localparam logic [2:0] AS_BASE1    = 3'd0;
   localparam logic [2:0] AS_REC      = 3'd1;
   localparam logic [2:0] AS_REC1     = 3'd2;
   localparam logic [2:0] AS_REC2     = 3'd3;
   localparam logic [2:0] AS_REC3     = 3'd4;
   localparam logic [2:0] AS_TGT_LIVE = 3'd5;
   localparam logic [2:0] AS_TGT1     = 3'd6;

   // jump conditions: taken jumps to target, otherwise step + 1
   localparam logic [2:0] JC_NEVER    = 3'd0;
   localparam logic [2:0] JC_ALWAYS   = 3'd1;
   localparam logic [2:0] JC_NO_START = 3'd2;
   localparam logic [2:0] JC_CNT_ZERO = 3'd3;
   localparam logic [2:0] JC_NO_MATCH = 3'd4;
   localparam logic [2:0] JC_OUT_BUSY = 3'd5;

   // program steps
   localparam logic [PC_W-1:0] STEP_IDLE     = 4'd0;
   localparam logic [PC_W-1:0] STEP_READ_CNT = 4'd1;
   localparam logic [PC_W-1:0] STEP_LOOP     = 4'd3;
   localparam logic [PC_W-1:0] STEP_SKIP     = 4'd11;
   localparam logic [PC_W-1:0] STEP_DONE     = 4'd15;

   typedef struct packed {
      logic [3:0]      op;
      logic [2:0]      asel;
      logic [2:0]      jcond;
      logic [PC_W-1:0] target;
   } ucode_type;

   typedef struct packed {
      logic start;
      logic cnt_zero;
      logic no_match;
      logic out_busy;
   } status_type;

   typedef struct packed {
      logic        updated;
      logic [15:0] next_offset;
      logic [7:0]  orth_shift;
      logic        is_accepting;
      logic        is_weak;
      logic        is_sink;
      logic        is_failed;
   } rsp_type;

   function automatic logic admissible(input logic acc, input logic sink, input logic eow);
      return eow ? acc : !sink;
   endfunction

   // control store; the done step wraps to idle when not held
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type uw;
      uw = '{op: OP_NOP, asel: AS_REC, jcond: JC_ALWAYS, target: STEP_IDLE};
      case (pc)
         4'd0: uw = '{op: OP_ACCEPT,   asel: AS_BASE1,    jcond: JC_NO_START,
                      target: STEP_IDLE};
         4'd1: uw = '{op: OP_NOP,      asel: AS_BASE1,    jcond: JC_NEVER,
                      target: STEP_IDLE};
         4'd2: uw = '{op: OP_LD_CNT,   asel: AS_REC,      jcond: JC_NEVER,
                      target: STEP_IDLE};
         4'd3: uw = '{op: OP_NOP,      asel: AS_REC,      jcond: JC_CNT_ZERO,
                      target: STEP_DONE};
         4'd4: uw = '{op: OP_NOP,      asel: AS_REC1,     jcond: JC_NO_MATCH,
                      target: STEP_SKIP};
         4'd5: uw = '{op: OP_LD_SHIFT, asel: AS_REC2,     jcond: JC_NEVER,
                      target: STEP_IDLE};
         4'd6: uw = '{op: OP_LD_HI,    asel: AS_REC3,     jcond: JC_NEVER,
                      target: STEP_IDLE};
         4'd7: uw = '{op: OP_LD_LO,    asel: AS_TGT_LIVE, jcond: JC_NEVER,
                      target: STEP_IDLE};
         4'd8: uw = '{op: OP_LD_FLAGS, asel: AS_TGT1,     jcond: JC_NEVER,
                      target: STEP_IDLE};
         4'd9: uw = '{op: OP_LD_SINK,  asel: AS_REC,      jcond: JC_NEVER,
                      target: STEP_IDLE};
         4'd10: uw = '{op: OP_UPDATE,  asel: AS_REC,      jcond: JC_NEVER,
                       target: STEP_IDLE};
         4'd11: uw = '{op: OP_ADVANCE, asel: AS_REC,      jcond: JC_ALWAYS,
                       target: STEP_LOOP};
         4'd15: uw = '{op: OP_FINISH,  asel: AS_REC,      jcond: JC_OUT_BUSY,
                       target: STEP_DONE};
         default: uw = '{op: OP_NOP, asel: AS_REC, jcond: JC_ALWAYS, target: STEP_IDLE};
      endcase
      return uw;
   endfunction

endpackage

// File: hw/rtl/sra_sequencer.sv
// ---------------------------------------------------------------------------
// sra_sequencer
// step counter over the control store with conditional jumps
// ---------------------------------------------------------------------------
`include "segment_rule_automaton_step_defines.svh"

module sra_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  sra_pkg::status_type  status,
   output sra_pkg::ucode_type   ctrl
);

   logic [sra_pkg::PC_W-1:0] pc_ff;
   logic [sra_pkg::PC_W-1:0] pc_in;
   logic                     take;

   assign ctrl = sra_pkg::ucode_rom(pc_ff);

   always_comb begin
      case (ctrl.jcond)
         sra_pkg::JC_NEVER:    take = 1'b0;
         sra_pkg::JC_ALWAYS:   take = 1'b1;
         sra_pkg::JC_NO_START: take = !status.start;
         sra_pkg::JC_CNT_ZERO: take = status.cnt_zero;
         sra_pkg::JC_NO_MATCH: take = status.no_match;
         sra_pkg::JC_OUT_BUSY: take = status.out_busy;
         default:              take = 1'b1;
      endcase
      pc_in = take ? ctrl.target : pc_ff + {{(sra_pkg::PC_W-1){1'b0}}, 1'b1};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= sra_pkg::STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   `SRA_ASSERT_NEXT(a_step_starts, (ctrl.op == sra_pkg::OP_ACCEPT) && status.start, pc_ff == sra_pkg::STEP_READ_CNT)
   `SRA_ASSERT_NEXT(a_done_holds, (ctrl.op == sra_pkg::OP_FINISH) && status.out_busy, pc_ff == sra_pkg::STEP_DONE)
   `SRA_ASSERT_NEXT(a_advance_loops, ctrl.op == sra_pkg::OP_ADVANCE, pc_ff == sra_pkg::STEP_LOOP)

endmodule

// File: hw/rtl/sra_datapath.sv
// ---------------------------------------------------------------------------
// sra_datapath
// image memory, scan registers, start register and result register
// ---------------------------------------------------------------------------
`include "segment_rule_automaton_step_defines.svh"

module sra_datapath #(
   parameter int IMAGE_BYTES = sra_pkg::IMAGE_BYTES_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  sra_pkg::ucode_type  ctrl,
   output sra_pkg::status_type status,
   input  logic                req_valid,
   input  logic                req_cmd,
   input  logic [15:0]         req_image_addr,
   input  logic [7:0]          req_image_byte,
   input  logic [15:0]         req_state_offset,
   input  logic [7:0]          req_segment_type,
   input  logic                req_at_word_end,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output sra_pkg::rsp_type    rsp_data,
   input  logic                csr_wr_en,
   input  logic [15:0]         csr_wr_data
);

   localparam int AW = $clog2(IMAGE_BYTES);

   logic [7:0]  mem [IMAGE_BYTES];
   logic [7:0]  rd_data_ff;
   logic [15:0] raddr;
   logic        wr_en;

   logic [15:0] start_ff;
   logic [15:0] base_ff;
   logic [15:0] rec_ff;
   logic [7:0]  cnt_ff;
   logic [7:0]  seg_ff;
   logic        eow_ff;
   logic        initial_ff;

   logic [7:0]  cand_shift_ff;
   logic [15:0] cand_target_ff;
   logic        cand_acc_ff;
   logic        cand_weak_ff;
   logic        cand_sink_ff;

   logic        found_ff;
   logic [7:0]  best_shift_ff;
   logic [15:0] best_target_ff;
   logic        best_acc_ff;
   logic        best_weak_ff;
   logic        best_sink_ff;

   logic             rsp_valid_ff;
   sra_pkg::rsp_type rsp_ff;
   sra_pkg::rsp_type rsp_in;
   logic             final_found;

   always_comb begin
      case (ctrl.asel)
         sra_pkg::AS_BASE1:    raddr = base_ff + 16'd1;
         sra_pkg::AS_REC:      raddr = rec_ff;
         sra_pkg::AS_REC1:     raddr = rec_ff + 16'd1;
         sra_pkg::AS_REC2:     raddr = rec_ff + 16'd2;
         sra_pkg::AS_REC3:     raddr = rec_ff + 16'd3;
         sra_pkg::AS_TGT_LIVE: raddr = {cand_target_ff[15:8], rd_data_ff};
         sra_pkg::AS_TGT1:     raddr = cand_target_ff + 16'd1;
         default:              raddr = rec_ff;
      endcase
   end

   assign wr_en = (ctrl.op == sra_pkg::OP_ACCEPT) && req_valid && !req_cmd;

   // image store, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[req_image_addr[AW-1:0]] <= req_image_byte;
      end
      rd_data_ff <= mem[raddr[AW-1:0]];
   end

   assign status.start    = req_valid && req_cmd;
   assign status.cnt_zero = (cnt_ff == 8'd0);
   assign status.no_match = (rd_data_ff != seg_ff);
   assign status.out_busy = rsp_valid_ff && !rsp_ready;

   always_comb begin
      final_found = found_ff &&
                    !(initial_ff && !sra_pkg::admissible(best_acc_ff, best_sink_ff, eow_ff));
      rsp_in              = '0;
      rsp_in.updated      = final_found;
      if (final_found) begin
         rsp_in.next_offset  = best_target_ff;
         rsp_in.orth_shift   = best_shift_ff;
         rsp_in.is_accepting = best_acc_ff;
         rsp_in.is_weak      = best_weak_ff;
         rsp_in.is_sink      = best_sink_ff;
         rsp_in.is_failed    = best_sink_ff && !best_acc_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            start_ff <= csr_wr_data;
         end
         if ((ctrl.op == sra_pkg::OP_FINISH) && !status.out_busy) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // scan payload
   always_ff @(posedge clock) begin
      case (ctrl.op)
         sra_pkg::OP_ACCEPT: begin
            if (status.start) begin
               base_ff    <= (req_state_offset == 16'd0) ? start_ff : req_state_offset;
               initial_ff <= (req_state_offset == 16'd0);
               seg_ff     <= req_segment_type;
               eow_ff     <= req_at_word_end;
               found_ff   <= 1'b0;
            end
         end
         sra_pkg::OP_LD_CNT: begin
            cnt_ff <= rd_data_ff;
            rec_ff <= base_ff + 16'd2;
         end
         sra_pkg::OP_LD_SHIFT: cand_shift_ff <= rd_data_ff;
         sra_pkg::OP_LD_HI:    cand_target_ff[15:8] <= rd_data_ff;
         sra_pkg::OP_LD_LO:    cand_target_ff[7:0] <= rd_data_ff;
         sra_pkg::OP_LD_FLAGS: begin
            cand_acc_ff  <= rd_data_ff[0];
            cand_weak_ff <= rd_data_ff[1];
         end
         sra_pkg::OP_LD_SINK:  cand_sink_ff <= (rd_data_ff == 8'd0);
         sra_pkg::OP_UPDATE: begin
            if (initial_ff || sra_pkg::admissible(cand_acc_ff, cand_sink_ff, eow_ff)) begin
               found_ff       <= 1'b1;
               best_shift_ff  <= cand_shift_ff;
               best_target_ff <= cand_target_ff;
               best_acc_ff    <= cand_acc_ff;
               best_weak_ff   <= cand_weak_ff;
               best_sink_ff   <= cand_sink_ff;
            end
         end
         sra_pkg::OP_ADVANCE: begin
            rec_ff <= rec_ff + 16'd4;
            cnt_ff <= cnt_ff - 8'd1;
         end
         sra_pkg::OP_FINISH: begin
            if (!status.out_busy) begin
               rsp_ff <= rsp_in;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `SRA_ASSERT_NOW(a_finish_into_free_slot, $rose(rsp_valid_ff), $past(ctrl.op) == sra_pkg::OP_FINISH)
   `SRA_ASSERT_NOW(a_miss_is_zero, rsp_valid_ff && !rsp_ff.updated, rsp_ff == '0)
   `SRA_ASSERT_NOW(a_no_write_mid_step, wr_en, ctrl.op == sra_pkg::OP_ACCEPT)

endmodule

// File: hw/rtl/segment_rule_automaton_step.sv
// ---------------------------------------------------------------------------
// segment_rule_automaton_step
// one transition step of a segmentation-rule automaton held as a byte image
//
//   channel  ports     direction  carries
//   req      req_*     in         image byte write or transition step
//   rsp      rsp_*     out        one result per step, none per write
//   csr      csr_*     in         start state offset
//
// a step walks every record of the state and reads the target state's flag
// and count bytes only for records whose type matches
// the step runs under the control store, one image byte read per cycle
// through the single read port of the image memory
// the next beat is taken while a finished result waits on rsp
// reset clears the step counter, the result valid and the start offset;
// the image is undefined until written
// ---------------------------------------------------------------------------
module segment_rule_automaton_step #(
   parameter int IMAGE_BYTES = sra_pkg::IMAGE_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [15:0] req_image_addr,
   input  logic [7:0]  req_image_byte,
   input  logic [15:0] req_state_offset,
   input  logic [7:0]  req_segment_type,
   input  logic        req_at_word_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_updated,
   output logic [15:0] rsp_next_offset,
   output logic [7:0]  rsp_orth_shift,
   output logic        rsp_is_accepting,
   output logic        rsp_is_weak,
   output logic        rsp_is_sink,
   output logic        rsp_is_failed,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   sra_pkg::ucode_type  ctrl;
   sra_pkg::status_type status;
   sra_pkg::rsp_type    rsp_data;

   sra_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   sra_datapath #(
      .IMAGE_BYTES (IMAGE_BYTES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .status           (status),
      .req_valid        (req_valid),
      .req_cmd          (req_cmd),
      .req_image_addr   (req_image_addr),
      .req_image_byte   (req_image_byte),
      .req_state_offset (req_state_offset),
      .req_segment_type (req_segment_type),
      .req_at_word_end  (req_at_word_end),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_data         (rsp_data),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   assign req_ready        = (ctrl.op == sra_pkg::OP_ACCEPT);
   assign rsp_updated      = rsp_data.updated;
   assign rsp_next_offset  = rsp_data.next_offset;
   assign rsp_orth_shift   = rsp_data.orth_shift;
   assign rsp_is_accepting = rsp_data.is_accepting;
   assign rsp_is_weak      = rsp_data.is_weak;
   assign rsp_is_sink      = rsp_data.is_sink;
   assign rsp_is_failed    = rsp_data.is_failed;

endmodule

// File: test/segment_rule_automaton_step_checker.sv
// ---------------------------------------------------------------------------
// segment_rule_automaton_step checker
// watches the req, rsp and csr ports of the automaton step block, keeps its
// own copy of the automaton image and start offset, predicts the result of
// every accepted step beat and compares each result beat field by field
// ---------------------------------------------------------------------------
package sra_tb_pkg;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_STEP  = 1'b1
   } req_cmd_type;

endpackage

module segment_rule_automaton_step_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_cmd,
   input  logic [15:0] req_image_addr,
   input  logic [7:0]  req_image_byte,
   input  logic [15:0] req_state_offset,
   input  logic [7:0]  req_segment_type,
   input  logic        req_at_word_end,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_updated,
   input  logic [15:0] rsp_next_offset,
   input  logic [7:0]  rsp_orth_shift,
   input  logic        rsp_is_accepting,
   input  logic        rsp_is_weak,
   input  logic        rsp_is_sink,
   input  logic        rsp_is_failed,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   output int          mismatch_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [7:0]       image_mem [0:65535];
   logic [15:0]      start_reg;
   sra_pkg::rsp_type expected_q [$];

   function automatic sra_pkg::rsp_type predict_transition(input logic [15:0] state_off,
                                                           input logic [7:0]  seg,
                                                           input logic        eow);
      sra_pkg::rsp_type best;
      sra_pkg::rsp_type cand;
      logic [15:0]      base;
      logic [15:0]      rec;
      logic [15:0]      tgt;
      logic [7:0]       flags;
      int               cnt;
      bit               from_start;
      bit               best_ok;
      bit               ok;
      from_start = (state_off == 16'd0);
      base = from_start ? start_reg : state_off;
      best = '0;
      best_ok = 1'b0;
      cnt = image_mem[16'(base + 16'd1)];
      for (int i = 0; i < cnt; i++) begin
         rec = 16'(base + 16'd2 + 16'(4 * i));
         if (image_mem[rec] == seg) begin
            tgt = {image_mem[16'(rec + 16'd2)], image_mem[16'(rec + 16'd3)]};
            flags = image_mem[tgt];
            cand.updated = 1'b1;
            cand.next_offset = tgt;
            cand.orth_shift = image_mem[16'(rec + 16'd1)];
            cand.is_accepting = flags[0];
            cand.is_weak = flags[1];
            cand.is_sink = (image_mem[16'(tgt + 16'd1)] == 8'd0);
            cand.is_failed = cand.is_sink && !cand.is_accepting;
            ok = eow ? cand.is_accepting : !cand.is_sink;
            // the start state takes the last match, other states the last admissible one
            if (from_start || ok) begin
               best = cand;
               best_ok = ok;
            end
         end
      end
      if (!best_ok) begin
         best = '0;
      end
      return best;
   endfunction

   task automatic compare_field(input string what, input logic [15:0] want,
                                input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      sra_pkg::rsp_type want;
      if (reset) begin
         start_reg = '0;
         expected_q.delete();
         mismatch_count = 0;
      end else begin
         if (csr_wr_en) begin
            start_reg = csr_wr_data;
         end
         if (req_valid && req_ready) begin
            if (req_cmd == sra_tb_pkg::CMD_WRITE) begin
               image_mem[req_image_addr] = req_image_byte;
            end else begin
               expected_q.push_back(predict_transition(req_state_offset, req_segment_type,
                                                       req_at_word_end));
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: result beat with nothing expected, expected none, actual %0h",
                        $time, rsp_next_offset);
               mismatch_count++;
            end else begin
               want = expected_q.pop_front();
               compare_field("updated", 16'(want.updated), 16'(rsp_updated));
               compare_field("next_offset", want.next_offset, rsp_next_offset);
               compare_field("orth_shift", 16'(want.orth_shift), 16'(rsp_orth_shift));
               compare_field("is_accepting", 16'(want.is_accepting), 16'(rsp_is_accepting));
               compare_field("is_weak", 16'(want.is_weak), 16'(rsp_is_weak));
               compare_field("is_sink", 16'(want.is_sink), 16'(rsp_is_sink));
               compare_field("is_failed", 16'(want.is_failed), 16'(rsp_is_failed));
            end
         end
      end
      pending <= expected_q.size();
   end

endmodule

// File: test/tb_segment_rule_automaton_step.sv
// ---------------------------------------------------------------------------
// tb_segment_rule_automaton_step
// builds small automata in the image with write beats, sets the start offset
// between phases and issues transition steps whose image reads only touch
// bytes already written; a directed set of states covers address wrap, the
// start-state rule and the last-admissible rule, then random phases follow
// with random idling on both channels; the checker predicts and compares
// ---------------------------------------------------------------------------
module tb_segment_rule_automaton_step;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          RANDOM_ITEMS  = 1900;
   localparam int          SETTLE_CYCLES = 40;
   localparam logic [15:0] WRAP_STATE    = 16'hFFFF;
   localparam logic [15:0] LEAF_STATE    = 16'h0010;
   localparam logic [15:0] MID_STATE     = 16'h8000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_cmd;
   logic [15:0] req_image_addr;
   logic [7:0]  req_image_byte;
   logic [15:0] req_state_offset;
   logic [7:0]  req_segment_type;
   logic        req_at_word_end;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_updated;
   logic [15:0] rsp_next_offset;
   logic [7:0]  rsp_orth_shift;
   logic        rsp_is_accepting;
   logic        rsp_is_weak;
   logic        rsp_is_sink;
   logic        rsp_is_failed;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;
   int          mismatch_count;
   int          pending;

   logic [7:0]  shadow_mem [0:65535];
   bit          shadow_set [0:65535];
   logic [15:0] cur_start;
   bit          quiet;
   int          items_sent;

   segment_rule_automaton_step dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_image_addr   (req_image_addr),
      .req_image_byte   (req_image_byte),
      .req_state_offset (req_state_offset),
      .req_segment_type (req_segment_type),
      .req_at_word_end  (req_at_word_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_updated      (rsp_updated),
      .rsp_next_offset  (rsp_next_offset),
      .rsp_orth_shift   (rsp_orth_shift),
      .rsp_is_accepting (rsp_is_accepting),
      .rsp_is_weak      (rsp_is_weak),
      .rsp_is_sink      (rsp_is_sink),
      .rsp_is_failed    (rsp_is_failed),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   segment_rule_automaton_step_checker step_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_image_addr   (req_image_addr),
      .req_image_byte   (req_image_byte),
      .req_state_offset (req_state_offset),
      .req_segment_type (req_segment_type),
      .req_at_word_end  (req_at_word_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_updated      (rsp_updated),
      .rsp_next_offset  (rsp_next_offset),
      .rsp_orth_shift   (rsp_orth_shift),
      .rsp_is_accepting (rsp_is_accepting),
      .rsp_is_weak      (rsp_is_weak),
      .rsp_is_sink      (rsp_is_sink),
      .rsp_is_failed    (rsp_is_failed),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .mismatch_count   (mismatch_count),
      .pending          (pending)
   );

   always #10 clock = ~clock;

   initial begin : time_limit
      #500ms;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic int idle_gap();
      int r;
      if (quiet) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end
      if (r < 85) begin
         return $urandom_range(1, 3);
      end
      if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   task automatic send_beat(input sra_tb_pkg::req_cmd_type cmd, input logic [15:0] addr,
                            input logic [7:0] data, input logic [15:0] off,
                            input logic [7:0] seg, input logic eow);
      int g;
      g = idle_gap();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_image_addr <= addr;
      req_image_byte <= data;
      req_state_offset <= off;
      req_segment_type <= seg;
      req_at_word_end <= eow;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic put_byte(input logic [15:0] addr, input logic [7:0] data);
      shadow_mem[addr] = data;
      shadow_set[addr] = 1'b1;
      send_beat(sra_tb_pkg::CMD_WRITE, addr, data, 16'($urandom), 8'($urandom),
                1'($urandom));
   endtask

   task automatic put_header(input logic [15:0] at, input logic [7:0] flags,
                             input logic [7:0] cnt);
      put_byte(at, flags);
      put_byte(16'(at + 16'd1), cnt);
   endtask

   task automatic put_record(input logic [15:0] at, input logic [7:0] typ,
                             input logic [7:0] shift, input logic [15:0] tgt);
      put_byte(at, typ);
      put_byte(16'(at + 16'd1), shift);
      put_byte(16'(at + 16'd2), tgt[15:8]);
      put_byte(16'(at + 16'd3), tgt[7:0]);
   endtask

   // only steps whose image reads all land on written bytes go out
   task automatic try_step(input logic [15:0] off, input logic [7:0] seg, input logic eow);
      logic [15:0] base;
      logic [15:0] rec;
      logic [15:0] tgt;
      int          cnt;
      bit          ok;
      base = (off == 16'd0) ? cur_start : off;
      rec = 16'(base + 16'd1);
      ok = shadow_set[rec];
      cnt = ok ? int'(shadow_mem[rec]) : 0;
      for (int i = 0; ok && i < cnt; i++) begin
         rec = 16'(base + 16'd2 + 16'(4 * i));
         ok = shadow_set[rec] && shadow_set[16'(rec + 16'd1)] &&
              shadow_set[16'(rec + 16'd2)] && shadow_set[16'(rec + 16'd3)];
         if (ok && shadow_mem[rec] == seg) begin
            tgt = {shadow_mem[16'(rec + 16'd2)], shadow_mem[16'(rec + 16'd3)]};
            ok = shadow_set[tgt] && shadow_set[16'(tgt + 16'd1)];
         end
      end
      if (ok) begin
         send_beat(sra_tb_pkg::CMD_STEP, 16'($urandom), 8'($urandom), off, seg, eow);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_start(input logic [15:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_start = value;
   endtask

   initial begin : result_sink
      int g;
      rsp_ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         g = idle_gap();
         if (g > 0) begin
            rsp_ready <= 1'b0;
            repeat (g) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      logic [15:0] state_offs [$];
      int          counts [$];
      logic [7:0]  type_pool [$];
      logic [15:0] pos;
      logic [15:0] off;
      logic [7:0]  seg;
      int          phase;
      int          nstates;
      int          nsteps;
      int          r;
      int          k;
      int          c;
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = sra_tb_pkg::CMD_WRITE;
      req_image_addr = '0;
      req_image_byte = '0;
      req_state_offset = '0;
      req_segment_type = '0;
      req_at_word_end = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      cur_start = '0;
      quiet = 1'b0;
      items_sent = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // wrap state: flags at the top byte, count and records from address 0
      put_header(WRAP_STATE, 8'hFE, 8'd2);
      put_record(16'h0001, 8'hFF, 8'h00, LEAF_STATE);
      put_record(16'h0005, 8'hFF, 8'hFF, MID_STATE);
      put_header(LEAF_STATE, 8'h03, 8'd0);
      put_header(MID_STATE, 8'h7C, 8'd2);
      put_record(16'(MID_STATE + 16'd2), 8'h00, 8'h5A, LEAF_STATE);
      put_record(16'(MID_STATE + 16'd6), 8'h00, 8'hA5, WRAP_STATE);
      drain();
      write_start(WRAP_STATE);
      try_step(16'd0, 8'hFF, 1'b1);
      try_step(16'd0, 8'hFF, 1'b0);
      try_step(WRAP_STATE, 8'hFF, 1'b1);
      try_step(16'd0, 8'h00, 1'b0);
      try_step(MID_STATE, 8'h00, 1'b1);
      try_step(MID_STATE, 8'h00, 1'b0);
      try_step(LEAF_STATE, 8'h00, 1'b1);

      phase = 0;
      while (items_sent < RANDOM_ITEMS) begin
         quiet = ($urandom_range(0, 3) == 0);
         nstates = $urandom_range(3, 8);
         if (phase == 0) begin
            pos = 16'h0000;
         end else if (phase == 1) begin
            pos = 16'hFFFF;
         end else begin
            pos = 16'($urandom);
         end
         state_offs.delete();
         counts.delete();
         type_pool.delete();
         repeat (3) type_pool.push_back(8'($urandom));
         for (int s = 0; s < nstates; s++) begin
            r = $urandom_range(0, 99);
            if (r < 20) begin
               c = 0;
            end else if (r < 90) begin
               c = $urandom_range(1, 4);
            end else if (r < 97) begin
               c = $urandom_range(5, 12);
            end else begin
               c = $urandom_range(20, 48);
            end
            state_offs.push_back(pos);
            counts.push_back(c);
            pos = 16'(pos + 16'(2 + 4 * c));
         end
         for (int s = 0; s < nstates; s++) begin
            put_header(state_offs[s], 8'($urandom), 8'(counts[s]));
            for (int j = 0; j < counts[s]; j++) begin
               seg = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                 : type_pool[$urandom_range(0, 2)];
               put_record(16'(state_offs[s] + 16'(2 + 4 * j)), seg, 8'($urandom),
                          state_offs[$urandom_range(0, nstates - 1)]);
            end
         end
         drain();
         write_start(phase < 2 ? state_offs[0] : state_offs[$urandom_range(0, nstates - 1)]);

         nsteps = $urandom_range(60, 100);
         for (int j = 0; j < nsteps; j++) begin
            r = $urandom_range(0, 99);
            k = $urandom_range(0, nstates - 1);
            if (r < 80) begin
               off = ($urandom_range(0, 3) == 0) ? 16'd0 : state_offs[k];
               seg = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                 : type_pool[$urandom_range(0, 2)];
               try_step(off, seg, 1'($urandom));
            end else if (r < 88) begin
               put_byte(16'($urandom), 8'($urandom));
            end else if (r < 94) begin
               // retype a record or change a state's flags
               if (counts[k] > 0) begin
                  put_byte(16'(state_offs[k] + 16'(2 + 4 * $urandom_range(0, counts[k] - 1))),
                           type_pool[$urandom_range(0, 2)]);
               end else begin
                  put_byte(state_offs[k], 8'($urandom));
               end
            end else begin
               try_step(16'($urandom), 8'($urandom), 1'($urandom));
            end
            if (phase == 2 && j == 30) begin
               drain();
            end
         end
         phase++;
      end

      drain();
      if (mismatch_count == 0 && pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: segment_rule_automaton_step.f
+incdir+hw/rtl
hw/rtl/sra_pkg.sv
hw/rtl/sra_sequencer.sv
hw/rtl/sra_datapath.sv
hw/rtl/segment_rule_automaton_step.sv
test/segment_rule_automaton_step_checker.sv
test/tb_segment_rule_automaton_step.sv
